/* rtl/fmo_pkg.sv */
// ----------------------------------------------------------------------------
// fmo_pkg
// Shared constants and the quarter-wave sine table generator for the
// two-operator FM oscillator.
// ----------------------------------------------------------------------------
package fmo_pkg;

  // Configuration register indexes.
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 31;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BASE_STEP  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CAR_RATIO  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MOD_RATIO  = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MOD_INDEX  = 2'd3;

  localparam int RATIO_BITS    = 8;
  localparam int ENV_BITS      = 16;
  localparam int ENV_FRAC      = 15;

  localparam logic [CFG_DATA_BITS-1:0] BASE_STEP_RESET = 31'd39370534;
  localparam logic [RATIO_BITS-1:0]    RATIO_RESET     = 8'd1;

  // One entry of the quarter-wave table, round(sin(pi/2*i/N) * A), evaluated
  // with a Taylor series in unsigned Q30. Used at elaboration only. The ten
  // series terms after x are written out; term k is divided by (2k)*(2k+1) and the
  // signs alternate starting with a subtraction.
  function automatic longint unsigned sine_entry(input int unsigned idx,
                                                 input int unsigned tbits,
                                                 input int unsigned sbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned amp;
    longint unsigned v;
    longint signed   sum;
    x    = (64'h6487ED51 * longint'(idx)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd420;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    amp = (64'd1 << (sbits - 1)) - 64'd1;
    v   = (longint'(sum) * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v;
  endfunction

endpackage

/* rtl/fmo_serial_mul.sv */
// ----------------------------------------------------------------------------
// fmo_serial_mul
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, the
// product wraps at the accumulator width.
// ----------------------------------------------------------------------------
module fmo_serial_mul #(
  parameter int AW = 47,
  parameter int MW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] mcand,
  input  logic [MW-1:0] mplier,
  output logic          busy,
  output logic [AW-1:0] product
);

  logic [AW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] mc_r, mc_nxt;
  logic [MW-1:0] mp_r, mp_nxt;
  logic          busy_r, busy_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = mcand;
      mp_nxt   = mplier;
      busy_nxt = |mplier;
    end else if (busy_r) begin
      // Add the shifted multiplicand when the current multiplier bit is set;
      // stop as soon as no set bits remain.
      acc_nxt  = mp_r[0] ? acc_r + mc_r : acc_r;
      mc_nxt   = mc_r << 1;
      mp_nxt   = mp_r >> 1;
      busy_nxt = |mp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

/* rtl/fmo_sine_rom.sv */
// ----------------------------------------------------------------------------
// fmo_sine_rom
// Quarter-wave sine lookup: quadrant folding over a constant table, result in
// sign and magnitude form.
// ----------------------------------------------------------------------------
module fmo_sine_rom #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic [PHASE_BITS-1:0]  phase,
  output logic [SAMPLE_BITS-2:0] mag,
  output logic                   neg
);
  import fmo_pkg::*;

  localparam int QLEN = 1 << SINE_TABLE_BITS;

  logic [SAMPLE_BITS-2:0]     tab [QLEN+1];
  logic [SINE_TABLE_BITS+1:0] top;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   addr;

  for (genvar g = 0; g <= QLEN; g++) begin : g_tab
    localparam longint unsigned V = sine_entry(g, SINE_TABLE_BITS, SAMPLE_BITS);
    assign tab[g] = V[SAMPLE_BITS-2:0];
  end

  assign top  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
  assign idx  = top[SINE_TABLE_BITS-1:0];
  // Odd quadrants run the table backwards.
  assign addr = top[SINE_TABLE_BITS] ? (SINE_TABLE_BITS+1)'(QLEN) - {1'b0, idx}
                                     : {1'b0, idx};
  assign mag  = tab[addr];
  assign neg  = top[SINE_TABLE_BITS+1];

endmodule

/* rtl/two_operator_fm_oscillator.sv */
// ----------------------------------------------------------------------------
// two_operator_fm_oscillator
// Two-operator FM oscillator: one output sample per envelope word, built
// around two bit-serial multipliers and a quarter-wave sine table.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Payload
// --------+-----------+-------------------------------------------------------
// in_     | slave     | tdata[15:0] mod_envelope, tdata[31:16] amp_envelope
// out_    | master    | tdata[SAMPLE_BITS-1:0] sample, zero padded to bytes
// cfg_    | write     | addr 0 base_phase_step, 1 carrier_ratio,
//         |           | 2 modulator_ratio, 3 modulation_index
//
// From acceptance until the sample is loaded into the output register, a
// word passes the carrier and modulator lookups and multiply stages A to D.
// The multiply chain dominates: the multipliers retire one bit per cycle
// and stop at the highest set bit, so a multiplier with fewer significant
// bits finishes sooner.
// Reset is synchronous and active low; it restores the register defaults and
// clears both phases. A new word is taken only while the datapath is idle; a
// sample waiting on out_tready does not block that, and the final update
// stalls only if the previous sample has not been taken yet.
// ----------------------------------------------------------------------------
module two_operator_fm_oscillator #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [15:0] mod_envelope, [31:16] amp_envelope
  input  logic [2*fmo_pkg::ENV_BITS-1:0]         in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [SAMPLE_BITS-1:0] sample, upper bits zero
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       out_tdata,
  input  logic                                   cfg_we,
  input  logic [fmo_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [fmo_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import fmo_pkg::*;

  localparam int FRAC = SAMPLE_BITS - 1;
  // Everything that feeds a phase is kept modulo 2^(PHASE_BITS+FRAC), which
  // is enough for the deviation product before its final shift.
  localparam int AW   = PHASE_BITS + FRAC;
  localparam int MW   = (SAMPLE_BITS > ENV_BITS) ? SAMPLE_BITS : ENV_BITS;
  localparam int OW   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [AW-1:0] POS_LIM = AW'((64'd1 << FRAC) - 64'd1);
  localparam logic [AW-1:0] NEG_LIM = AW'(64'd1 << FRAC);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_LOOK_CAR = 12'b000000000010,
    ST_LOOK_MOD = 12'b000000000100,
    ST_MUL_A    = 12'b000000001000,
    ST_WAIT_A   = 12'b000000010000,
    ST_MUL_B    = 12'b000000100000,
    ST_WAIT_B   = 12'b000001000000,
    ST_MUL_C    = 12'b000010000000,
    ST_WAIT_C   = 12'b000100000000,
    ST_MUL_D    = 12'b001000000000,
    ST_WAIT_D   = 12'b010000000000,
    ST_UPDATE   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_BITS-1:0] base_step_r;
  logic [RATIO_BITS-1:0]    car_ratio_r, mod_ratio_r, mod_index_r;
  logic [PHASE_BITS-1:0]    car_phase_r, mod_phase_r;
  logic [ENV_BITS-1:0]      mod_env_r, amp_env_r;
  logic [SAMPLE_BITS-2:0]   car_mag_r, mod_mag_r;
  logic                     car_neg_r, mod_neg_r;
  logic [SAMPLE_BITS-1:0]   sample_r, sample_nxt;
  logic [MW-1:0]            m_mag_r;
  logic [AW-1:0]            mod_step_r;
  logic                     out_tvalid_r;
  logic [OW-1:0]            out_tdata_r;

  // Shared sine lookup, pointed at the carrier or the modulator phase.
  logic [PHASE_BITS-1:0]    rom_phase;
  logic [SAMPLE_BITS-2:0]   rom_mag;
  logic                     rom_neg;

  // Multiplier controls.
  logic                     mul0_start, mul1_start;
  logic [AW-1:0]            mul0_mcand, mul1_mcand;
  logic [MW-1:0]            mul0_mplier, mul1_mplier;
  logic                     mul0_busy, mul1_busy;
  logic [AW-1:0]            mul0_product, mul1_product;

  logic [AW-1:0]            smp_mag;
  logic [PHASE_BITS-1:0]    dev_mag;
  logic [PHASE_BITS-1:0]    car_step;
  logic                     in_acc;
  logic                     out_free;
  logic                     mul_idle;

  assign rom_phase = (state_r == ST_LOOK_CAR) ? car_phase_r : mod_phase_r;

  fmo_sine_rom #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_sine (
    .phase (rom_phase),
    .mag   (rom_mag),
    .neg   (rom_neg)
  );

  // Operand selection. Stage A scales both sines by their envelopes, stage B
  // forms the two frequency steps, stage C the deviation depth and stage D
  // the deviation itself.
  always_comb begin
    mul0_start  = 1'b0;
    mul1_start  = 1'b0;
    mul0_mcand  = AW'(car_mag_r);
    mul0_mplier = MW'(amp_env_r);
    mul1_mcand  = AW'(mod_mag_r);
    mul1_mplier = MW'(mod_env_r);
    case (state_r)
      ST_MUL_A: begin
        mul0_start = 1'b1;
        mul1_start = 1'b1;
      end
      ST_MUL_B: begin
        mul0_start  = 1'b1;
        mul1_start  = 1'b1;
        mul0_mcand  = AW'(base_step_r);
        mul0_mplier = MW'(mod_ratio_r);
        mul1_mcand  = AW'(base_step_r);
        mul1_mplier = MW'(car_ratio_r);
      end
      ST_MUL_C: begin
        mul0_start  = 1'b1;
        mul0_mcand  = mod_step_r;
        mul0_mplier = MW'(mod_index_r);
      end
      ST_MUL_D: begin
        mul0_start  = 1'b1;
        mul0_mcand  = mul0_product;
        mul0_mplier = m_mag_r;
      end
      default: begin
      end
    endcase
  end

  fmo_serial_mul #(.AW(AW), .MW(MW)) u_mul0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul0_start),
    .mcand   (mul0_mcand),
    .mplier  (mul0_mplier),
    .busy    (mul0_busy),
    .product (mul0_product)
  );

  fmo_serial_mul #(.AW(AW), .MW(MW)) u_mul1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul1_start),
    .mcand   (mul1_mcand),
    .mplier  (mul1_mplier),
    .busy    (mul1_busy),
    .product (mul1_product)
  );

  // Output sample: magnitude truncated toward zero, then saturated to the
  // signed range before the sign is applied.
  assign smp_mag = mul0_product >> ENV_FRAC;
  always_comb begin
    if (car_neg_r) begin
      sample_nxt = (smp_mag > NEG_LIM) ? -SAMPLE_BITS'(NEG_LIM)
                                       : -SAMPLE_BITS'(smp_mag);
    end else begin
      sample_nxt = (smp_mag > POS_LIM) ? SAMPLE_BITS'(POS_LIM)
                                       : SAMPLE_BITS'(smp_mag);
    end
  end

  // The deviation keeps the sign of the modulator sine; mul1 still holds the
  // carrier step from stage B.
  assign dev_mag  = mul0_product[AW-1:FRAC];
  assign car_step = mul1_product[PHASE_BITS-1:0] + (mod_neg_r ? -dev_mag : dev_mag);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign mul_idle = !mul0_busy && !mul1_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_LOOK_CAR;
      ST_LOOK_CAR: state_nxt = ST_LOOK_MOD;
      ST_LOOK_MOD: state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_WAIT_A;
      ST_WAIT_A:   if (mul_idle) state_nxt = ST_MUL_B;
      ST_MUL_B:    state_nxt = ST_WAIT_B;
      ST_WAIT_B:   if (mul_idle) state_nxt = ST_MUL_C;
      ST_MUL_C:    state_nxt = ST_WAIT_C;
      ST_WAIT_C:   if (mul_idle) state_nxt = ST_MUL_D;
      ST_MUL_D:    state_nxt = ST_WAIT_D;
      ST_WAIT_D:   if (mul_idle) state_nxt = ST_UPDATE;
      ST_UPDATE:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_step_r  <= BASE_STEP_RESET;
      car_ratio_r  <= RATIO_RESET;
      mod_ratio_r  <= RATIO_RESET;
      mod_index_r  <= RATIO_RESET;
      car_phase_r  <= '0;
      mod_phase_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BASE_STEP: base_step_r <= cfg_data;
          CFG_CAR_RATIO: car_ratio_r <= cfg_data[RATIO_BITS-1:0];
          CFG_MOD_RATIO: mod_ratio_r <= cfg_data[RATIO_BITS-1:0];
          CFG_MOD_INDEX: mod_index_r <= cfg_data[RATIO_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_UPDATE && out_free) begin
        out_tvalid_r <= 1'b1;
        mod_phase_r  <= mod_phase_r + mod_step_r[PHASE_BITS-1:0];
        car_phase_r  <= car_phase_r + car_step;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mod_env_r <= in_tdata[ENV_BITS-1:0];
      amp_env_r <= in_tdata[2*ENV_BITS-1:ENV_BITS];
    end
    if (state_r == ST_LOOK_CAR) begin
      car_mag_r <= rom_mag;
      car_neg_r <= rom_neg;
    end
    if (state_r == ST_LOOK_MOD) begin
      mod_mag_r <= rom_mag;
      mod_neg_r <= rom_neg;
    end
    if (state_r == ST_WAIT_A && mul_idle) begin
      sample_r <= sample_nxt;
      m_mag_r  <= MW'(mul1_product >> ENV_FRAC);
    end
    if (state_r == ST_WAIT_B && mul_idle) begin
      mod_step_r <= mul0_product;
    end
    if (state_r == ST_UPDATE && out_free) begin
      out_tdata_r <= OW'(sample_r);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The multipliers are quiet whenever no word is in flight.
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mul0_busy && !mul1_busy)
    else $error("multiplier busy while idle");

  // An accepted word always starts with the carrier lookup.
  a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LOOK_CAR)
    else $error("accepted word did not start the lookup");

  // Phases move only in the update step.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_UPDATE |=> $stable(car_phase_r) && $stable(mod_phase_r))
    else $error("phase changed outside update");

  // A new sample appears only out of the update step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_UPDATE)
    else $error("sample presented without an update");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-operator FM oscillator. A directed table of
// envelope words runs first, then random words in bursts under several
// register settings, with a random receiver stall pattern and one long hold.
// ----------------------------------------------------------------------------
module testbench;
  import fmo_pkg::*;

  localparam int PB = 32;
  localparam int TB = 10;
  localparam int SB = 16;
  localparam int QN = 1 << TB;
  localparam longint SAMP_MAX = (64'd1 << (SB - 1)) - 1;
  localparam int LIMIT_CYCLES = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] mod_envelope, [31:16] amp_envelope
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] sample
  logic        cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  two_operator_fm_oscillator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // The oscillator state as the bench sees it, plus its own sine table.
  longint signed   quarter_tab[QN+1];
  longint unsigned base_step;
  longint unsigned car_ratio;
  longint unsigned mod_ratio;
  longint unsigned mod_index;
  longint unsigned car_phase;
  longint unsigned mod_phase;

  logic [15:0] samples_due[$];
  int          mismatches;
  int          cycle_count;
  logic        hold_long;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Quarter-wave table, evaluated the same way the hardware table is built:
  // a Taylor series in unsigned Q30, rounded and clamped to full scale.
  task automatic build_sine;
    longint unsigned x, x2, term;
    longint signed   acc;
    longint signed   v;
    for (int i = 0; i <= QN; i++) begin
      x    = (64'h6487ED51 * longint'(i)) >> TB;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      if (acc < 0) acc = 0;
      v = (longint'(acc) * SAMP_MAX + (64'd1 << 29)) >>> 30;
      if (v > SAMP_MAX) v = SAMP_MAX;
      quarter_tab[i] = v;
    end
  endtask

  function automatic longint signed sine_at(longint unsigned ph);
    longint unsigned top;
    int unsigned quad, idx;
    longint signed v;
    top  = ph >> (PB - 2 - TB);
    quad = (top >> TB) & 3;
    idx  = top & (QN - 1);
    v = (quad & 1) ? quarter_tab[QN - idx] : quarter_tab[idx];
    return (quad & 2) ? -v : v;
  endfunction

  // Unsigned times signed, shifted right, truncated toward zero.
  function automatic longint signed mul_shift(longint unsigned u, longint signed s, int sh);
    longint unsigned mag, r;
    mag = (s < 0) ? -s : s;
    r = (u * mag) >> sh;
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Computes the sample for one envelope word and advances both phases.
  function automatic logic [15:0] next_sample(logic [15:0] menv, logic [15:0] aenv);
    longint signed s_car, s_mod, smp, m, dev;
    longint unsigned mstep, depth, cstep;
    s_car = sine_at(car_phase);
    s_mod = sine_at(mod_phase);
    smp = mul_shift(aenv, s_car, 15);
    if (smp > SAMP_MAX) smp = SAMP_MAX;
    if (smp < -SAMP_MAX - 1) smp = -SAMP_MAX - 1;
    mstep = base_step * mod_ratio;
    depth = mstep * mod_index;
    m     = mul_shift(menv, s_mod, 15);
    dev   = mul_shift(depth, m, SB - 1);
    cstep = base_step * car_ratio + longint'(dev);
    mod_phase = (mod_phase + mstep) & 64'hFFFF_FFFF;
    car_phase = (car_phase + cstep) & 64'hFFFF_FFFF;
    return smp[15:0];
  endfunction

  // One register write; the write enable is then dropped before the task returns.
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] a, longint unsigned d);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (a)
      CFG_BASE_STEP: base_step = d & 64'h7FFF_FFFF;
      CFG_CAR_RATIO: car_ratio = d & 64'hFF;
      CFG_MOD_RATIO: mod_ratio = d & 64'hFF;
      CFG_MOD_INDEX: mod_index = d & 64'hFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one word and holds it until the block takes it. The expected
  // sample is queued at the acceptance edge so that ordering is exact.
  task automatic send_word(logic [15:0] menv, logic [15:0] aenv);
    in_tvalid <= 1'b1;
    in_tdata  <= {aenv, menv};
    do @(posedge clk); while (!in_tready);
    samples_due.push_back(next_sample(menv, aenv));
  endtask

  task automatic idle_cycles(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits for every queued sample, then lets the datapath settle before a
  // register write.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_env;
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Random words in bursts, with a random gap after some of the bursts.
  task automatic random_words(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++, left--) begin
        send_word(rand_env(), rand_env());
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 90));
    end
  endtask

  // Receiver: random stall pattern, with a stretch of full readiness, and
  // a long hold-off when requested.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
      end else if ((cycle_count / 3000) % 4 == 1) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker: every accepted sample is compared with the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %h", out_tdata);
      end else begin
        logic [15:0] want;
        want = samples_due.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample mismatch: expected %h, got %h", want, out_tdata);
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Directed words: {mod_envelope, amp_envelope, known sample or -1}.
  // Only the first sample is fixed: after reset the carrier phase is zero,
  // so the sine and the sample are zero whatever the envelopes. Every other
  // row is checked against the predictor.
  typedef struct {
    logic [15:0] menv;
    logic [15:0] aenv;
    int          want;
  } env_pair_t;

  env_pair_t directed_tab[] = '{
    '{16'hFFFF, 16'hFFFF, 0},
    '{16'd0, 16'd32768, -1}, '{16'd32768, 16'd32768, -1}, '{16'hFFFF, 16'hFFFF, -1},
    '{16'hFFFF, 16'd0, -1}, '{16'd0, 16'hFFFF, -1}, '{16'd32768, 16'd0, -1},
    '{16'h5555, 16'hAAAA, -1}, '{16'hAAAA, 16'h5555, -1}, '{16'd1, 16'd1, -1},
    '{16'hFFFF, 16'hFFFF, -1}, '{16'h8000, 16'hFFFF, -1}, '{16'h7FFF, 16'h7FFF, -1},
    '{16'hFFFF, 16'hFFFF, -1}, '{16'hFFFF, 16'hFFFF, -1}, '{16'd0, 16'hFFFF, -1},
    '{16'h1234, 16'hFEDC, -1}
  };

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    hold_long = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    build_sine();
    base_step = 39370534;
    car_ratio = 1;
    mod_ratio = 1;
    mod_index = 1;
    car_phase = 0;
    mod_phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tab[i]) begin
      send_word(directed_tab[i].menv, directed_tab[i].aenv);
      if (directed_tab[i].want >= 0 &&
          samples_due[samples_due.size()-1] !== 16'(directed_tab[i].want)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("directed row %0d: expected %h, predicted %h", i,
                   16'(directed_tab[i].want), samples_due[samples_due.size()-1]);
        end
      end
    end
    drain();

    // Quarter-turn base step with ratio one and no modulation; with an envelope
    // above 1.0 a large sine magnitude drives the sample into saturation.
    write_reg(CFG_BASE_STEP, 64'h4000_0000);
    write_reg(CFG_MOD_INDEX, 0);
    for (int i = 0; i < 8; i++) send_word(16'hFFFF, 16'hFFFF);
    drain();

    // Setting sweep, extremes included; zero ratios and index are covered.
    for (int phase_n = 0; phase_n < 8; phase_n++) begin
      case (phase_n)
        0: begin
          write_reg(CFG_BASE_STEP, 64'h7FFF_FFFF);
          write_reg(CFG_CAR_RATIO, 255);
          write_reg(CFG_MOD_RATIO, 255);
          write_reg(CFG_MOD_INDEX, 255);
        end
        1: begin
          write_reg(CFG_BASE_STEP, 0);
          write_reg(CFG_CAR_RATIO, 0);
          write_reg(CFG_MOD_RATIO, 0);
          write_reg(CFG_MOD_INDEX, 0);
        end
        2: begin
          write_reg(CFG_BASE_STEP, 39370534);
          write_reg(CFG_CAR_RATIO, 1);
          write_reg(CFG_MOD_RATIO, 2);
          write_reg(CFG_MOD_INDEX, 5);
        end
        default: begin
          write_reg(CFG_BASE_STEP, {$urandom, $urandom} & 64'h7FFF_FFFF);
          write_reg(CFG_CAR_RATIO, $urandom_range(0, 255));
          write_reg(CFG_MOD_RATIO, $urandom_range(0, 255));
          write_reg(CFG_MOD_INDEX, $urandom_range(0, 255));
        end
      endcase
      if (phase_n == 3) begin
        // Long receiver hold while words keep coming, so the block backs up.
        hold_long = 1'b1;
        fork
          begin
            repeat (600) @(posedge clk);
            hold_long = 1'b0;
          end
          random_words(20);
        join
      end
      random_words(60);
      drain();
    end

    if (mismatches == 0 && samples_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fmo_pkg.sv
rtl/fmo_serial_mul.sv
rtl/fmo_sine_rom.sv
rtl/two_operator_fm_oscillator.sv
tb/sv/testbench.sv
